FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define WFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also looks at the reset cycles.
`define WFM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/wfm_pkg.sv
package wfm_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd5;

    // headings
    localparam logic [1:0] DIR_PROW = 2'd0;
    localparam logic [1:0] DIR_PCOL = 2'd1;
    localparam logic [1:0] DIR_NROW = 2'd2;
    localparam logic [1:0] DIR_NCOL = 2'd3;

    // epoch tag on seen entries
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic idle;
        logic done;
        logic reachable;
    } t_walk_sts;

endpackage

FILE: rtl/core/wfm_wall_mem.sv
module wfm_wall_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr1,
    output logic                     o_rd_data0,
    output logic                     o_rd_data1
);

    logic mem [DEPTH];
    logic r_rd0;
    logic r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd0 <= mem[i_rd_addr0];
        r_rd1 <= mem[i_rd_addr1];
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

FILE: rtl/core/wfm_seen_mem.sv
module wfm_seen_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [3:0]               o_rd_bits,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [3:0]               i_wr_bits,
    input  logic                     i_advance,
    output logic                     o_busy
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = wfm_pkg::EPOCH_W;
    localparam logic [EW-1:0] EPOCH_MAX = {EW{1'b1}};

    // entry = {epoch tag, one seen bit per heading}; tag 0 is never a live epoch
    logic [EW+3:0] mem [DEPTH];
    logic [EW+3:0] r_rd;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [EW-1:0] r_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EW'(1);
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end else if (i_advance) begin
            if (r_epoch == EPOCH_MAX) begin
                // tags are about to repeat: wipe the store first
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
                r_epoch    <= EW'(1);
            end else begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= {r_epoch, i_wr_bits};
        end
        r_rd <= mem[i_rd_addr];
    end

    // stale tag reads as an untouched entry
    assign o_rd_bits = (r_rd[EW+3:4] == r_epoch) ? r_rd[3:0] : 4'b0000;
    assign o_busy    = r_clearing;

endmodule

FILE: rtl/core/wfm_walker.sv
module wfm_walker #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [$clog2(MAX_ROWS+1)-1:0]              i_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0]              i_cols,
    input  logic [wfm_pkg::CFG_W-1:0]                  i_start_row,
    input  logic [wfm_pkg::CFG_W-1:0]                  i_start_col,
    input  logic [wfm_pkg::CFG_W-1:0]                  i_goal_row,
    input  logic [wfm_pkg::CFG_W-1:0]                  i_goal_col,
    output wfm_pkg::t_walk_sts                         o_sts,
    input  logic                                       i_res_take,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       o_seen_rd_addr,
    input  logic [3:0]                                 i_seen_rd_bits,
    output logic                                       o_seen_wr_en,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       o_seen_wr_addr,
    output logic [3:0]                                 o_seen_wr_bits,
    output logic                                       o_seen_advance,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       o_wall_rd_addr0,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       o_wall_rd_addr1,
    input  logic                                       i_wall_rd_data0,
    input  logic                                       i_wall_rd_data1
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int PW  = RW + CNW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_LOOK = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic          ok;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [AW-1:0] idx;
    } t_nbr;

    function automatic t_nbr f_nbr(
        input logic [1:0]     dir,
        input logic [RW-1:0]  row,
        input logic [CW-1:0]  col,
        input logic [AW-1:0]  idx,
        input logic [RNW-1:0] rows,
        input logic [CNW-1:0] cols
    );
        t_nbr n;
        n.ok  = 1'b0;
        n.row = row;
        n.col = col;
        n.idx = idx;
        unique case (dir)
            wfm_pkg::DIR_PROW: begin
                n.ok  = (32'(row) + 1) < 32'(rows);
                n.row = row + 1'b1;
                n.idx = idx + AW'(cols);
            end
            wfm_pkg::DIR_PCOL: begin
                n.ok  = (32'(col) + 1) < 32'(cols);
                n.col = col + 1'b1;
                n.idx = idx + 1'b1;
            end
            wfm_pkg::DIR_NROW: begin
                n.ok  = (row != '0);
                n.row = row - 1'b1;
                n.idx = idx - AW'(cols);
            end
            wfm_pkg::DIR_NCOL: begin
                n.ok  = (col != '0);
                n.col = col - 1'b1;
                n.idx = idx - 1'b1;
            end
        endcase
        return n;
    endfunction

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_idx, n_idx;
    logic [1:0]    r_head, n_head;
    logic [RW-1:0] r_goal_row, n_goal_row;
    logic [CW-1:0] r_goal_col, n_goal_col;
    t_nbr          r_left, n_left;
    t_nbr          r_fwd, n_fwd;
    logic          r_reach, n_reach;

    t_nbr          w_left;
    t_nbr          w_fwd;
    logic          w_start_ok;
    logic          w_goal_ok;
    logic [RW-1:0] w_sr;
    logic [CW-1:0] w_sc;
    logic [PW-1:0] w_prod;
    logic [AW-1:0] w_start_idx;

    assign w_left = f_nbr(r_head + 2'd1, r_row, r_col, r_idx, i_rows, i_cols);
    assign w_fwd  = f_nbr(r_head, r_row, r_col, r_idx, i_rows, i_cols);

    // one-based positions; zero or past the edge is outside
    assign w_start_ok = (i_start_row != '0) && (32'(i_start_row) <= 32'(i_rows)) &&
                        (i_start_col != '0) && (32'(i_start_col) <= 32'(i_cols));
    assign w_goal_ok  = (i_goal_row != '0) && (32'(i_goal_row) <= 32'(i_rows)) &&
                        (i_goal_col != '0) && (32'(i_goal_col) <= 32'(i_cols));

    assign w_sr        = RW'(i_start_row - 1'b1);
    assign w_sc        = CW'(i_start_col - 1'b1);
    assign w_prod      = w_sr * i_cols;
    assign w_start_idx = AW'(w_prod + PW'(w_sc));

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_col          = r_col;
        n_idx          = r_idx;
        n_head         = r_head;
        n_goal_row     = r_goal_row;
        n_goal_col     = r_goal_col;
        n_left         = r_left;
        n_fwd          = r_fwd;
        n_reach        = r_reach;
        o_seen_wr_en   = 1'b0;
        o_seen_wr_bits = i_seen_rd_bits | (4'b0001 << r_head);
        o_seen_advance = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_goal_row = RW'(i_goal_row - 1'b1);
                n_goal_col = CW'(i_goal_col - 1'b1);
                if (w_start_ok && w_goal_ok) begin
                    n_row   = w_sr;
                    n_col   = w_sc;
                    n_idx   = w_start_idx;
                    n_head  = wfm_pkg::DIR_PCOL;
                    n_state = S_LOOK;
                end else begin
                    n_reach = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                // reads of seen[idx] and both neighbor walls go out this cycle
                if (r_row == r_goal_row && r_col == r_goal_col) begin
                    n_reach = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_left  = w_left;
                    n_fwd   = w_fwd;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_seen_rd_bits[r_head]) begin
                    n_reach = 1'b0;
                    n_state = S_DONE;
                end else begin
                    // written back before the next LOOK reads, so no overlap
                    o_seen_wr_en = 1'b1;
                    n_state      = S_LOOK;
                    if (r_left.ok && !i_wall_rd_data0) begin
                        n_head = r_head + 2'd1;
                        n_row  = r_left.row;
                        n_col  = r_left.col;
                        n_idx  = r_left.idx;
                    end else if (r_fwd.ok && !i_wall_rd_data1) begin
                        n_row = r_fwd.row;
                        n_col = r_fwd.col;
                        n_idx = r_fwd.idx;
                    end else begin
                        n_head = r_head + 2'd3;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    o_seen_advance = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= wfm_pkg::DIR_PCOL;
            r_reach <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_reach <= n_reach;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_idx      <= n_idx;
        r_goal_row <= n_goal_row;
        r_goal_col <= n_goal_col;
        r_left     <= n_left;
        r_fwd      <= n_fwd;
    end

    assign o_seen_rd_addr  = r_idx;
    assign o_seen_wr_addr  = r_idx;
    assign o_wall_rd_addr0 = w_left.idx;
    assign o_wall_rd_addr1 = w_fwd.idx;

    assign o_sts.idle      = (r_state == S_IDLE);
    assign o_sts.done      = (r_state == S_DONE);
    assign o_sts.reachable = r_reach;

endmodule

FILE: rtl/core/wall_follower_maze_walk.sv
// Channel   Direction  Handshake                   Payload
// in        in         i_in_valid / o_in_ready     i_cell_wall, i_last_cell
// out       out        o_out_valid / i_out_ready   o_reachable
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Cells load one item per cycle into the wall memory while no walk is running.
// The last cell starts a walk: a setup state, then per step a registered read
// of seen and wall memories, then seen write-back; up to 4*rows*cols steps.
// Results wait in an output register; cells keep loading meanwhile.
// Reset is synchronous, active low. A clearing pass over every seen entry
// follows reset and every 255th walk (seen tag wrap); input is held off then.
// Config writes are taken every cycle.
module wall_follower_maze_walk #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cell_wall,
    input  logic                          i_last_cell,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_reachable,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int STORE = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(STORE);
    localparam int LW    = $clog2(STORE + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 1);
    localparam int CNW   = $clog2(MAX_COLS + 1);
    localparam int CFW   = wfm_pkg::CFG_W;

    logic [CFW-1:0] r_row_count;
    logic [CFW-1:0] r_col_count;
    logic [CFW-1:0] r_start_row;
    logic [CFW-1:0] r_start_col;
    logic [CFW-1:0] r_goal_row;
    logic [CFW-1:0] r_goal_col;
    logic [LW-1:0]  r_load_idx;
    logic           r_out_valid;
    logic           r_reachable;

    wfm_pkg::t_walk_sts w_sts;
    logic           w_in_acc;
    logic           w_wall_we;
    logic           w_seen_busy;
    logic [RNW-1:0] w_rows;
    logic [CNW-1:0] w_cols;
    logic [AW-1:0]  w_seen_rd_addr;
    logic [3:0]     w_seen_rd_bits;
    logic           w_seen_wr_en;
    logic [AW-1:0]  w_seen_wr_addr;
    logic [3:0]     w_seen_wr_bits;
    logic           w_seen_advance;
    logic [AW-1:0]  w_wall_rd_addr0;
    logic [AW-1:0]  w_wall_rd_addr1;
    logic           w_wall_rd_data0;
    logic           w_wall_rd_data1;
    logic           w_out_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFW'(1);
            r_col_count <= CFW'(1);
            r_start_row <= CFW'(1);
            r_start_col <= CFW'(1);
            r_goal_row  <= CFW'(1);
            r_goal_col  <= CFW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wfm_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                wfm_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                wfm_pkg::CFG_START_ROW: r_start_row <= i_cfg_data;
                wfm_pkg::CFG_START_COL: r_start_col <= i_cfg_data;
                wfm_pkg::CFG_GOAL_ROW:  r_goal_row  <= i_cfg_data;
                wfm_pkg::CFG_GOAL_COL:  r_goal_col  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counts above the store size clamp to it
    assign w_rows = (32'(r_row_count) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(r_row_count);
    assign w_cols = (32'(r_col_count) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(r_col_count);

    assign o_in_ready = w_sts.idle && !w_seen_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    // cells past the store are dropped
    assign w_wall_we  = w_in_acc && (32'(r_load_idx) < STORE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
        end else if (w_in_acc) begin
            if (i_last_cell) begin
                r_load_idx <= '0;
            end else if (w_wall_we) begin
                r_load_idx <= r_load_idx + 1'b1;
            end
        end
    end

    assign w_out_load = w_sts.done && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_reachable <= w_sts.reachable;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_reachable = r_reachable;

    wfm_wall_mem #(
        .DEPTH (STORE)
    ) u_wall_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_wall_we),
        .i_wr_addr  (r_load_idx[AW-1:0]),
        .i_wr_data  (i_cell_wall),
        .i_rd_addr0 (w_wall_rd_addr0),
        .i_rd_addr1 (w_wall_rd_addr1),
        .o_rd_data0 (w_wall_rd_data0),
        .o_rd_data1 (w_wall_rd_data1)
    );

    wfm_seen_mem #(
        .DEPTH (STORE)
    ) u_seen_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_seen_rd_addr),
        .o_rd_bits (w_seen_rd_bits),
        .i_wr_en   (w_seen_wr_en),
        .i_wr_addr (w_seen_wr_addr),
        .i_wr_bits (w_seen_wr_bits),
        .i_advance (w_seen_advance),
        .o_busy    (w_seen_busy)
    );

    wfm_walker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_in_acc && i_last_cell),
        .i_rows          (w_rows),
        .i_cols          (w_cols),
        .i_start_row     (r_start_row),
        .i_start_col     (r_start_col),
        .i_goal_row      (r_goal_row),
        .i_goal_col      (r_goal_col),
        .o_sts           (w_sts),
        .i_res_take      (!r_out_valid),
        .o_seen_rd_addr  (w_seen_rd_addr),
        .i_seen_rd_bits  (w_seen_rd_bits),
        .o_seen_wr_en    (w_seen_wr_en),
        .o_seen_wr_addr  (w_seen_wr_addr),
        .o_seen_wr_bits  (w_seen_wr_bits),
        .o_seen_advance  (w_seen_advance),
        .o_wall_rd_addr0 (w_wall_rd_addr0),
        .o_wall_rd_addr1 (w_wall_rd_addr1),
        .i_wall_rd_data0 (w_wall_rd_data0),
        .i_wall_rd_data1 (w_wall_rd_data1)
    );

endmodule

FILE: rtl/core/wfm_checker.sv
`include "assert_macros.svh"

module wfm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_last_cell,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_reachable
);

    // reset leaves no result and starts the clearing pass
    `WFM_ASSERT_RST(a_reset_quiet, !i_rst_n |=> (!o_out_valid && !o_in_ready), "reset state wrong")

    // a last cell starts a walk, so no item is taken in the next cycle
    `WFM_ASSERT(a_walk_blocks, (i_in_valid && o_in_ready && i_last_cell) |=> !o_in_ready, "input taken during walk")

    // a result only shows up out of a running walk
    `WFM_ASSERT(a_result_from_walk, $rose(o_out_valid) |-> $past(!o_in_ready), "result without walk")

    `WFM_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_reachable)), "stalled result changed")

endmodule

bind wall_follower_maze_walk wfm_checker u_wfm_checker (.*);
